>>> hdl/spsc_pkg.sv
// shared types and constants of the sprite pixel shadow compositor
`timescale 1ns / 1ps

package spsc_pkg;

   // request type codes on the input channel
   localparam logic [1:0] REQ_COMPOSE = 2'd0;
   localparam logic [1:0] REQ_CLEAR   = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTEN       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKS_SPRITES  = 2'd3;

   // register reset values
   localparam logic [9:0] SCREEN_WIDTH_RESET  = 10'd320;
   localparam logic [8:0] SCREEN_HEIGHT_RESET = 9'd224;

   // pixel math constants
   localparam logic [7:0]  DARKEN_K        = 8'h9d;
   localparam logic [7:0]  HIGHLIGHT_ADD   = 8'h22;
   localparam logic [7:0]  PRI_SHADOW_MARK = 8'h20;
   localparam logic [7:0]  PRI_SHADOW_LOCK = 8'h80;
   localparam logic [7:0]  PRI_LEVEL_MAX   = 8'h1f;
   localparam logic [31:0] MASK_UNMASKED   = 32'hffffffff;
   localparam logic [31:0] MASK_FORCE      = 32'h80000000;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // operation decided by the front end
   typedef enum logic [1:0] {
      OP_COMPOSE,
      OP_CLEAR,
      OP_READ,
      OP_CLIP
   } op_type;

   // classified command, address travels beside it
   typedef struct packed {
      op_type      op;
      logic        shadow;
      logic        unmasked;
      logic [23:0] rgb;
      logic [31:0] mask;
   } cmd_type;

   // blend controls for the back end
   typedef struct packed {
      logic brighten_en;
      logic marks_sprites;
   } blend_cfg_type;

endpackage

>>> hdl/spsc_if.sv
// channel interfaces: request, response and register write
`timescale 1ns / 1ps

interface spsc_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic signed [10:0]  pos_x;
   logic signed [10:0]  pos_y;
   logic [7:0]          pen;
   logic [3:0]          pen_bits;
   logic [23:0]         palette_rgb;
   logic [31:0]         priority_mask;

   modport source (output valid, req_type, pos_x, pos_y, pen, pen_bits, palette_rgb,
                   priority_mask, input ready);
   modport sink (input valid, req_type, pos_x, pos_y, pen, pen_bits, palette_rgb,
                 priority_mask, output ready);
endinterface

interface spsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_rgb;
   logic [7:0]  pixel_priority;
   logic        on_screen;
   logic        written;

   modport source (output valid, pixel_rgb, pixel_priority, on_screen, written, input ready);
   modport sink (input valid, pixel_rgb, pixel_priority, on_screen, written, output ready);
endinterface

interface spsc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [spsc_pkg::CSR_IDX_W-1:0]     index;
   logic [spsc_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/spsc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module spsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array and read register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/spsc_queue.sv
// short command queue between the front and back ends
`timescale 1ns / 1ps

module spsc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = spsc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill count stays within the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count above depth");

   // a lone push raises the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

>>> hdl/spsc_front.sv
// front end: accepts request beats, clips and classifies them
`timescale 1ns / 1ps

module spsc_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256
) (
   spsc_req_if.sink                                      req,
   input  logic [9:0]                                    screen_width,
   input  logic [8:0]                                    screen_height,
   output logic                                          push_valid,
   input  logic                                          push_ready,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       push_addr,
   output spsc_pkg::cmd_type                             push_cmd
);

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WIDTH);
   localparam logic [11:0] WIDTH_LIMIT  = 12'(MAX_WIDTH);
   localparam logic [11:0] HEIGHT_LIMIT = 12'(MAX_HEIGHT);

   logic [11:0] width_eff;
   logic [11:0] height_eff;
   logic        on_screen;
   logic [3:0]  bits_eff;
   logic [7:0]  shadow_pen;

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   // visible area after saturation to the store size
   always_comb begin
      width_eff  = (12'(screen_width) > WIDTH_LIMIT) ? WIDTH_LIMIT : 12'(screen_width);
      height_eff = (12'(screen_height) > HEIGHT_LIMIT) ? HEIGHT_LIMIT : 12'(screen_height);
      on_screen  = !req.pos_x[10] && (12'(req.pos_x[9:0]) < width_eff) &&
                   !req.pos_y[10] && (12'(req.pos_y[9:0]) < height_eff);
   end

   // shadow pen from the clamped pen width
   always_comb begin
      if (req.pen_bits == 4'd0) begin
         bits_eff = 4'd1;
      end else if (req.pen_bits > 4'd8) begin
         bits_eff = 4'd8;
      end else begin
         bits_eff = req.pen_bits;
      end
      shadow_pen = 8'((9'd1 << bits_eff) - 9'd1);
   end

   // classify the beat and form the store address
   always_comb begin
      push_cmd.rgb      = req.palette_rgb;
      push_cmd.mask     = req.priority_mask | spsc_pkg::MASK_FORCE;
      push_cmd.unmasked = (req.priority_mask == spsc_pkg::MASK_UNMASKED);
      push_cmd.shadow   = (req.pen == shadow_pen);
      push_addr         = '0;
      if (!on_screen) begin
         push_cmd.op = spsc_pkg::OP_CLIP;
      end else begin
         push_addr = ADDR_W'(ADDR_W'(req.pos_y[9:0]) * ROW_STRIDE) +
                     ADDR_W'(req.pos_x[9:0]);
         case (req.req_type)
            spsc_pkg::REQ_COMPOSE: begin
               push_cmd.op = (req.pen == 8'd0) ? spsc_pkg::OP_READ : spsc_pkg::OP_COMPOSE;
            end
            spsc_pkg::REQ_CLEAR: begin
               push_cmd.op = spsc_pkg::OP_CLEAR;
            end
            default: begin
               push_cmd.op = spsc_pkg::OP_READ;
            end
         endcase
      end
   end

endmodule

>>> hdl/spsc_back.sv
// back end: read-modify-write of the color and priority stores
`timescale 1ns / 1ps

module spsc_back #(
   parameter int DEPTH = 131072
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  logic [$clog2(DEPTH)-1:0]      pop_addr,
   input  spsc_pkg::cmd_type             pop_cmd,
   input  spsc_pkg::blend_cfg_type       blend_cfg,
   spsc_rsp_if.source                    rsp
);

   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type          state_ff, state_in;
   spsc_pkg::cmd_type  cur_ff;
   logic [ADDR_W-1:0]  cur_addr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_rgb_ff;
   logic [7:0]         rsp_pri_ff;
   logic               rsp_on_ff;
   logic               rsp_written_ff;

   logic               pop;
   logic               rd_en;
   logic [23:0]        old_col;
   logic [7:0]         old_pri;
   logic [23:0]        blended;
   logic               level_open;
   logic [23:0]        new_col;
   logic [7:0]         new_pri;
   logic               new_wr;
   logic               new_on;
   logic               out_free;
   logic               fire;
   logic               wr_en;

   // per channel darken: c * 157 / 256
   function automatic logic [7:0] darken8(input logic [7:0] c);
      logic [15:0] prod;
      prod = 16'(c) * 16'(spsc_pkg::DARKEN_K);
      return prod[15:8];
   endfunction

   // per channel brighten with saturation
   function automatic logic [7:0] brighten8(input logic [7:0] c);
      logic [8:0] sum;
      sum = 9'(c) + 9'(spsc_pkg::HIGHLIGHT_ADD);
      return sum[8] ? 8'hff : sum[7:0];
   endfunction

   assign pop_ready = (state_ff == ST_IDLE);
   assign pop       = pop_valid && pop_ready;
   assign rd_en     = pop && (pop_cmd.op != spsc_pkg::OP_CLIP);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fire      = (state_ff == ST_EXEC) && out_free;
   assign wr_en     = fire && new_wr;

   // color and priority stores
   spsc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_color_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_addr_ff),
      .wr_data (new_col),
      .rd_en   (rd_en),
      .rd_addr (pop_addr),
      .rd_data (old_col)
   );

   spsc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_priority_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_addr_ff),
      .wr_data (new_pri),
      .rd_en   (rd_en),
      .rd_addr (pop_addr),
      .rd_data (old_pri)
   );

   // shadow blend of the stored color
   always_comb begin
      if (blend_cfg.brighten_en) begin
         blended = {brighten8(old_col[23:16]), brighten8(old_col[15:8]),
                    brighten8(old_col[7:0])};
      end else begin
         blended = {darken8(old_col[23:16]), darken8(old_col[15:8]),
                    darken8(old_col[7:0])};
      end
      level_open = !cur_ff.mask[old_pri[4:0]];
   end

   // new pixel contents
   always_comb begin
      new_col = old_col;
      new_pri = old_pri;
      new_wr  = 1'b0;
      new_on  = 1'b1;
      case (cur_ff.op)
         spsc_pkg::OP_CLEAR: begin
            new_col = cur_ff.rgb;
            new_pri = 8'd0;
            new_wr  = 1'b1;
         end
         spsc_pkg::OP_COMPOSE: begin
            if (cur_ff.unmasked) begin
               new_wr = 1'b1;
               if (cur_ff.shadow) begin
                  new_col = blended;
                  if (blend_cfg.marks_sprites) begin
                     new_pri = old_pri | spsc_pkg::PRI_SHADOW_MARK;
                  end
               end else begin
                  new_col = ((old_pri & spsc_pkg::PRI_SHADOW_MARK) != 8'd0) ?
                            blended : cur_ff.rgb;
               end
            end else if (cur_ff.shadow) begin
               if (level_open && ((old_pri & spsc_pkg::PRI_SHADOW_LOCK) == 8'd0)) begin
                  new_col = blended;
                  new_pri = blend_cfg.marks_sprites ?
                            (spsc_pkg::PRI_SHADOW_LOCK | spsc_pkg::PRI_SHADOW_MARK) :
                            spsc_pkg::PRI_SHADOW_LOCK;
                  new_wr  = 1'b1;
               end
            end else if (level_open) begin
               new_col = ((old_pri & spsc_pkg::PRI_SHADOW_MARK) != 8'd0) ?
                         blended : cur_ff.rgb;
               new_pri = (old_pri & spsc_pkg::PRI_SHADOW_LOCK) | spsc_pkg::PRI_LEVEL_MAX;
               new_wr  = 1'b1;
            end
         end
         spsc_pkg::OP_CLIP: begin
            new_col = 24'd0;
            new_pri = 8'd0;
            new_on  = 1'b0;
         end
         default: begin
            new_wr = 1'b0;
         end
      endcase
   end

   // sequencer next state and response valid
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state, current command and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         cur_ff      <= pop_cmd;
         cur_addr_ff <= pop_addr;
      end
      if (fire) begin
         rsp_rgb_ff     <= new_col;
         rsp_pri_ff     <= new_pri;
         rsp_on_ff      <= new_on;
         rsp_written_ff <= new_wr;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.pixel_rgb      = rsp_rgb_ff;
   assign rsp.pixel_priority = rsp_pri_ff;
   assign rsp.on_screen      = rsp_on_ff;
   assign rsp.written        = rsp_written_ff;

   // stores are written only while finishing a command
   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_EXEC))
      else $error("store write outside execute");

   // a clipped beat carries zeros and no write
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_on_ff) |->
         (!rsp_written_ff && (rsp_rgb_ff == 24'd0) && (rsp_pri_ff == 8'd0)))
      else $error("clipped beat not cleared");

endmodule

>>> hdl/sprite_pixel_shadow_compositor_top.sv
// Top level of the sprite pixel compositor: registers, front end, queue, back end.
// Path of a beat: queue slot, back end command register and store read, response register.
// The back end takes no new beat until the store read and write of the last one finish.
// The front end keeps taking beats into a two-entry queue while the back end works.
// Reset clears control state and loads register defaults; store contents stay undefined.
// Stores are not swept after reset, so requests are taken from the first cycle.
`timescale 1ns / 1ps

module sprite_pixel_shadow_compositor_top #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256
) (
   input  logic       clock,
   input  logic       reset,
   spsc_req_if.sink   req_ch,
   spsc_rsp_if.source rsp_ch,
   spsc_csr_if.sink   csr_ch
);

   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = ADDR_W + $bits(spsc_pkg::cmd_type);

   logic [9:0]               screen_width_ff;
   logic [8:0]               screen_height_ff;
   logic                     brighten_ff;
   logic                     marks_sprites_ff;
   logic                     csr_write;

   logic                     push_valid;
   logic                     push_ready;
   logic [ADDR_W-1:0]        push_addr;
   spsc_pkg::cmd_type        push_cmd;
   logic                     pop_valid;
   logic                     pop_ready;
   logic [ENTRY_W-1:0]       pop_entry;
   logic [ADDR_W-1:0]        pop_addr;
   spsc_pkg::cmd_type        pop_cmd;
   spsc_pkg::blend_cfg_type  blend_cfg;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff   <= spsc_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff  <= spsc_pkg::SCREEN_HEIGHT_RESET;
         brighten_ff       <= 1'b0;
         marks_sprites_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_ch.index)
            spsc_pkg::CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_ch.data[9:0];
            spsc_pkg::CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_ch.data[8:0];
            spsc_pkg::CSR_BRIGHTEN:       brighten_ff       <= csr_ch.data[0];
            spsc_pkg::CSR_MARKS_SPRITES:  marks_sprites_ff  <= csr_ch.data[0];
            default: begin
               brighten_ff <= brighten_ff;
            end
         endcase
      end
   end

   assign blend_cfg.brighten_en    = brighten_ff;
   assign blend_cfg.marks_sprites  = marks_sprites_ff;

   // clip and classify
   spsc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .req           (req_ch),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_addr     (push_addr),
      .push_cmd      (push_cmd)
   );

   // command queue
   spsc_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_addr, push_cmd}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   assign pop_addr = pop_entry[ENTRY_W-1 -: ADDR_W];
   assign pop_cmd  = spsc_pkg::cmd_type'(pop_entry[$bits(spsc_pkg::cmd_type)-1:0]);

   // store read-modify-write
   spsc_back #(.DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_addr  (pop_addr),
      .pop_cmd   (pop_cmd),
      .blend_cfg (blend_cfg),
      .rsp       (rsp_ch)
   );

endmodule

>>> tb/tb_sprite_pixel_shadow_compositor_top.sv
// self-checking testbench of the sprite pixel compositor: directed and random pixel traffic
`timescale 1ns / 1ps

module tb_sprite_pixel_shadow_compositor_top;

   localparam int FRAME_W     = 512;
   localparam int FRAME_H     = 256;
   localparam int FRAME_DEPTH = FRAME_W * FRAME_H;
   localparam int STALL_LIMIT = 2000;

   // request code with no operation of its own, handled as a read
   localparam logic [1:0] REQ_SPARE = 2'd3;

   typedef struct {
      logic [1:0]         kind;
      logic signed [10:0] x;
      logic signed [10:0] y;
      logic [7:0]         pen;
      logic [3:0]         pen_bits;
      logic [23:0]        rgb;
      logic [31:0]        mask;
   } pixel_req_type;

   typedef struct {
      logic [23:0] rgb;
      logic [7:0]  pri;
      logic        on_screen;
      logic        written;
   } pixel_rsp_type;

   logic clock = 1'b0;
   logic reset;

   spsc_req_if req_ch ();
   spsc_rsp_if rsp_ch ();
   spsc_csr_if csr_ch ();

   sprite_pixel_shadow_compositor_top #(
      .MAX_WIDTH  (FRAME_W),
      .MAX_HEIGHT (FRAME_H)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the frame and priority stores plus the register file
   logic [23:0] frame_rgb [FRAME_DEPTH];
   logic [7:0]  frame_pri [FRAME_DEPTH];
   bit          frame_valid [FRAME_DEPTH];
   int unsigned filled_q [$];
   logic [9:0]  cfg_width;
   logic [8:0]  cfg_height;
   logic        cfg_highlight;
   logic        cfg_marks;

   pixel_rsp_type pixel_results_q [$];
   int            mismatch_count = 0;
   int            send_idle_pct  = 22;
   int            recv_idle_pct  = 46;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int visible_width();
      return (cfg_width > FRAME_W) ? FRAME_W : int'(cfg_width);
   endfunction

   function automatic int visible_height();
      return (cfg_height > FRAME_H) ? FRAME_H : int'(cfg_height);
   endfunction

   // all-ones pen for a pen width, out of range widths clamp to 1..8
   function automatic logic [7:0] shadow_pen_of(logic [3:0] bits);
      int nbits;
      nbits = (bits == 0) ? 1 : (bits > 8) ? 8 : int'(bits);
      return 8'((1 << nbits) - 1);
   endfunction

   // darken to c*157/256 per channel, or brighten by a fixed step with saturation
   function automatic logic [23:0] shade_rgb(logic [23:0] c);
      logic [23:0] o;
      logic [8:0]  sum;
      logic [15:0] prod;
      for (int i = 0; i < 3; i++) begin
         if (cfg_highlight) begin
            sum = {1'b0, c[8*i +: 8]} + {1'b0, spsc_pkg::HIGHLIGHT_ADD};
            o[8*i +: 8] = sum[8] ? 8'hff : sum[7:0];
         end else begin
            prod = c[8*i +: 8] * spsc_pkg::DARKEN_K;
            o[8*i +: 8] = prod[15:8];
         end
      end
      return o;
   endfunction

   // expected result of one pixel request, updates the shadow stores
   function automatic pixel_rsp_type composite_pixel(pixel_req_type r);
      pixel_rsp_type res;
      int            px;
      int            py;
      int unsigned   addr;
      logic [23:0]   color;
      logic [7:0]    pri;
      logic [7:0]    shadow;
      logic [31:0]   gate_mask;
      logic          level_open;
      logic          wr;
      res = '{rgb: '0, pri: '0, on_screen: 1'b0, written: 1'b0};
      px = r.x;
      py = r.y;
      if (px < 0 || px >= visible_width() || py < 0 || py >= visible_height())
         return res;
      addr   = py * FRAME_W + px;
      color  = frame_rgb[addr];
      pri    = frame_pri[addr];
      shadow = shadow_pen_of(r.pen_bits);
      wr     = 1'b0;
      if (r.kind == spsc_pkg::REQ_CLEAR) begin
         color = r.rgb;
         pri   = '0;
         wr    = 1'b1;
      end else if (r.kind == spsc_pkg::REQ_COMPOSE && r.pen != 0) begin
         if (r.mask == spsc_pkg::MASK_UNMASKED) begin
            if (r.pen == shadow) begin
               color = shade_rgb(color);
               if (cfg_marks)
                  pri = pri | spsc_pkg::PRI_SHADOW_MARK;
            end else begin
               color = ((pri & spsc_pkg::PRI_SHADOW_MARK) != 0) ? shade_rgb(color) : r.rgb;
            end
            wr = 1'b1;
         end else begin
            gate_mask  = r.mask | spsc_pkg::MASK_FORCE;
            level_open = !gate_mask[pri & spsc_pkg::PRI_LEVEL_MAX];
            if (r.pen == shadow) begin
               if (level_open && (pri & spsc_pkg::PRI_SHADOW_LOCK) == 0) begin
                  color = shade_rgb(color);
                  pri   = cfg_marks ?
                          (spsc_pkg::PRI_SHADOW_LOCK | spsc_pkg::PRI_SHADOW_MARK) :
                          spsc_pkg::PRI_SHADOW_LOCK;
                  wr    = 1'b1;
               end
            end else if (level_open) begin
               color = ((pri & spsc_pkg::PRI_SHADOW_MARK) != 0) ? shade_rgb(color) : r.rgb;
               pri   = (pri & spsc_pkg::PRI_SHADOW_LOCK) | spsc_pkg::PRI_LEVEL_MAX;
               wr    = 1'b1;
            end
         end
      end
      if (wr) begin
         frame_rgb[addr] = color;
         frame_pri[addr] = pri;
         if (!frame_valid[addr]) begin
            frame_valid[addr] = 1'b1;
            filled_q.push_back(addr);
         end
      end
      res = '{rgb: color, pri: pri, on_screen: 1'b1, written: wr};
      return res;
   endfunction

   function automatic pixel_req_type make_pixel(logic [1:0] kind, int x, int y,
                                                logic [7:0] pen, logic [3:0] bits,
                                                logic [23:0] rgb, logic [31:0] mask);
      pixel_req_type r;
      r = '{kind: kind, x: 11'(x), y: 11'(y), pen: pen, pen_bits: bits, rgb: rgb, mask: mask};
      return r;
   endfunction

   // random pixel request; reads and composes only touch pixels already written
   function automatic pixel_req_type random_pixel_req();
      pixel_req_type r;
      int            w;
      int            h;
      int            roll;
      int unsigned   addr;
      bit            found;
      w = visible_width();
      h = visible_height();
      r.rgb      = 24'($urandom());
      r.pen_bits = ($urandom_range(99) < 85) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
      roll = $urandom_range(99);
      r.pen = (roll < 35) ? shadow_pen_of(r.pen_bits) :
              (roll < 45) ? 8'd0 : 8'($urandom_range(255));
      roll = $urandom_range(99);
      r.mask = (roll < 40) ? spsc_pkg::MASK_UNMASKED : (roll < 50) ? 32'd0 :
               (roll < 55) ? ~spsc_pkg::MASK_FORCE : $urandom();
      roll = $urandom_range(99);
      // clipped beats of any type
      if (roll < 6 || w == 0 || h == 0) begin
         r.kind = 2'($urandom_range(3));
         r.x    = 11'($urandom());
         r.y    = 11'($urandom());
         if (r.x >= 0 && r.x < w && r.y >= 0 && r.y < h)
            r.x = -r.x - 1;
         return r;
      end
      // most traffic lands on a small hot corner so that pixels stack up
      r.x = 11'($urandom_range(((w < 8) ? w : 8) - 1));
      r.y = 11'($urandom_range(((h < 4) ? h : 4) - 1));
      if (roll < 20) begin
         r.kind = spsc_pkg::REQ_CLEAR;
         if ($urandom_range(1) == 1) begin
            r.x = 11'($urandom_range(w - 1));
            r.y = 11'($urandom_range(h - 1));
         end
         return r;
      end
      roll   = $urandom_range(99);
      r.kind = (roll < 80) ? spsc_pkg::REQ_COMPOSE :
               (roll < 94) ? spsc_pkg::REQ_READ : REQ_SPARE;
      found  = frame_valid[int'(r.y) * FRAME_W + int'(r.x)];
      for (int t = 0; t < 4 && !found && filled_q.size() != 0; t++) begin
         addr = filled_q[$urandom_range(filled_q.size() - 1)];
         if (addr % FRAME_W < w && addr / FRAME_W < h) begin
            r.x   = 11'(addr % FRAME_W);
            r.y   = 11'(addr / FRAME_W);
            found = 1'b1;
         end
      end
      if (!found)
         r.kind = spsc_pkg::REQ_CLEAR;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // one request beat, with random idle cycles ahead of it
   task automatic send_pixel(pixel_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= r.kind;
      req_ch.pos_x         <= r.x;
      req_ch.pos_y         <= r.y;
      req_ch.pen           <= r.pen;
      req_ch.pen_bits      <= r.pen_bits;
      req_ch.palette_rgb   <= r.rgb;
      req_ch.priority_mask <= r.mask;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pixel_results_q.push_back(composite_pixel(r));
   endtask

   // hold requests until every expected result has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pixel_results_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [spsc_pkg::CSR_IDX_W-1:0] idx,
                            logic [spsc_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      case (idx)
         spsc_pkg::CSR_SCREEN_WIDTH:  cfg_width     = value;
         spsc_pkg::CSR_SCREEN_HEIGHT: cfg_height    = value[8:0];
         spsc_pkg::CSR_BRIGHTEN:      cfg_highlight = value[0];
         spsc_pkg::CSR_MARKS_SPRITES: cfg_marks     = value[0];
         default: ;
      endcase
   endtask

   task automatic set_screen(int w, int h, bit highlight, bit marks);
      drain_results();
      write_reg(spsc_pkg::CSR_SCREEN_WIDTH, 10'(w));
      write_reg(spsc_pkg::CSR_SCREEN_HEIGHT, 10'(h));
      write_reg(spsc_pkg::CSR_BRIGHTEN, 10'(highlight));
      write_reg(spsc_pkg::CSR_MARKS_SPRITES, 10'(marks));
   endtask

   // random beats with one full pause halfway
   task automatic run_random(int items);
      for (int n = 0; n < items; n++) begin
         if (n == items / 2)
            drain_results();
         send_pixel(random_pixel_req());
      end
   endtask

   // default registers: pen cases, screen corners and clipping at every edge
   task automatic test_clip_and_defaults();
      send_pixel(make_pixel(spsc_pkg::REQ_CLEAR, 0, 0, 8'h00, 4'd1, 24'hffffff,
                            spsc_pkg::MASK_UNMASKED));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h00, 4'd4, 24'h123456,
                            spsc_pkg::MASK_UNMASKED));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h0f, 4'd4, 24'h123456,
                            spsc_pkg::MASK_UNMASKED));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h05, 4'd4, 24'h123456,
                            spsc_pkg::MASK_UNMASKED));
      send_pixel(make_pixel(spsc_pkg::REQ_CLEAR, 319, 223, 8'h00, 4'd8, 24'h00ff80, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 320, 0, 8'h05, 4'd8, 24'h111111,
                            spsc_pkg::MASK_UNMASKED));
      send_pixel(make_pixel(spsc_pkg::REQ_CLEAR, 0, 224, 8'h00, 4'd8, 24'h222222, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_READ, -1, -1, 8'h00, 4'd8, 24'h000000, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, -1024, 1023, 8'hff, 4'd8, 24'h333333,
                            32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_CLEAR, 1023, -1024, 8'h00, 4'd8, 24'h444444,
                            32'd0));
   endtask

   // highlight mode with shadow marks: masked gating, lock bit, forced top level
   task automatic test_shadow_highlight();
      set_screen(320, 224, 1'b1, 1'b1);
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'hff, 4'd8, 24'h000000,
                            spsc_pkg::MASK_UNMASKED));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h10, 4'd8, 24'habcdef,
                            spsc_pkg::MASK_UNMASKED));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h10, 4'd8, 24'habcdef, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h01, 4'd8, 24'habcdef, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_CLEAR, 0, 0, 8'h00, 4'd8, 24'hde10dd, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h01, 4'd0, 24'h000000,
                            32'hfffffffe));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h01, 4'd0, 24'h000000,
                            32'hfffffffe));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h80, 4'd15, 24'h765432,
                            ~spsc_pkg::MASK_FORCE));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h80, 4'd15, 24'h765432, 32'd0));
      send_pixel(make_pixel(REQ_SPARE, 0, 0, 8'h00, 4'd8, 24'h000000, 32'd0));
   endtask

   // zero, minimum and oversized screen sizes
   task automatic test_screen_extremes();
      set_screen(0, 224, 1'b0, 1'b0);
      send_pixel(make_pixel(spsc_pkg::REQ_READ, 0, 0, 8'h00, 4'd8, 24'h000000, 32'd0));
      set_screen(320, 0, 1'b0, 1'b0);
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 0, 0, 8'h05, 4'd8, 24'h000000,
                            spsc_pkg::MASK_UNMASKED));
      set_screen(1, 1, 1'b0, 1'b0);
      send_pixel(make_pixel(spsc_pkg::REQ_READ, 0, 0, 8'h00, 4'd8, 24'h000000, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_COMPOSE, 1, 0, 8'h05, 4'd8, 24'h000000,
                            spsc_pkg::MASK_UNMASKED));
      set_screen(1023, 511, 1'b0, 1'b0);
      send_pixel(make_pixel(spsc_pkg::REQ_CLEAR, 511, 255, 8'h00, 4'd8, 24'h5a5a5a, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_READ, 511, 255, 8'h00, 4'd8, 24'h000000, 32'd0));
      send_pixel(make_pixel(spsc_pkg::REQ_READ, 512, 0, 8'h00, 4'd8, 24'h000000, 32'd0));
   endtask

   task automatic test_random_marked_shadows();
      set_screen(16, 8, 1'b0, 1'b1);
      send_idle_pct = 22;
      recv_idle_pct = 46;
      run_random(700);
   endtask

   task automatic test_random_highlight_full();
      set_screen(512, 256, 1'b1, 1'b0);
      send_idle_pct = 46;
      recv_idle_pct = 22;
      run_random(700);
   endtask

   task automatic test_random_oversized();
      set_screen(1023, 511, 1'b1, 1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(350);
   endtask

   task automatic test_random_narrow();
      set_screen(37, 1, 1'b0, 1'b0);
      run_random(200);
   endtask

   // response side backpressure
   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

   // compare each response beat with the oldest expected pixel
   always @(posedge clock) begin : check_results
      pixel_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pixel_results_q.size() == 0) begin
            report_mismatch("response beat with nothing expected", 32'(rsp_ch.pixel_rgb), 0);
         end else begin
            want = pixel_results_q.pop_front();
            if (rsp_ch.pixel_rgb !== want.rgb)
               report_mismatch("pixel_rgb", 32'(rsp_ch.pixel_rgb), 32'(want.rgb));
            if (rsp_ch.pixel_priority !== want.pri)
               report_mismatch("pixel_priority", 32'(rsp_ch.pixel_priority), 32'(want.pri));
            if (rsp_ch.on_screen !== want.on_screen)
               report_mismatch("on_screen", 32'(rsp_ch.on_screen), 32'(want.on_screen));
            if (rsp_ch.written !== want.written)
               report_mismatch("written", 32'(rsp_ch.written), 32'(want.written));
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
             (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
            stalled = 0;
         else
            stalled++;
      end
      $display("ERROR %0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // test sequence
   initial begin : run_tests
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = spsc_pkg::REQ_COMPOSE;
      req_ch.pos_x         = '0;
      req_ch.pos_y         = '0;
      req_ch.pen           = '0;
      req_ch.pen_bits      = '0;
      req_ch.palette_rgb   = '0;
      req_ch.priority_mask = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = spsc_pkg::CSR_SCREEN_WIDTH;
      csr_ch.data          = '0;
      cfg_width            = spsc_pkg::SCREEN_WIDTH_RESET;
      cfg_height           = spsc_pkg::SCREEN_HEIGHT_RESET;
      cfg_highlight        = 1'b0;
      cfg_marks            = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_clip_and_defaults();
      test_shadow_highlight();
      test_screen_extremes();
      test_random_marked_shadows();
      test_random_highlight_full();
      test_random_oversized();
      test_random_narrow();

      drain_results();
      repeat (8) @(posedge clock);
      if (pixel_results_q.size() != 0)
         report_mismatch("results never returned", pixel_results_q.size(), 0);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
